[hw/rtl/mqttp_pkg.sv]
// ----------------------------------------------------------------------------
// mqttp_pkg
// Shared codes, constants and the result record for the inbound packet parser.
// ----------------------------------------------------------------------------
package mqttp_pkg;

  // parse phases; a body phase doubles as the role of the bytes it covers
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_TOPLEN  = 3'd2;
  localparam logic [2:0] PH_TOPIC   = 3'd3;
  localparam logic [2:0] PH_ID      = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_OTHER   = 3'd6;

  // control packet types
  localparam logic [3:0] TYPE_PUBLISH = 4'd3;
  localparam logic [3:0] TYPE_PUBACK  = 4'd4;
  localparam logic [3:0] TYPE_PUBREC  = 4'd5;
  localparam logic [3:0] TYPE_PUBREL  = 4'd6;
  localparam logic [3:0] TYPE_PUBCOMP = 4'd7;

  // reply and acknowledgment kinds
  localparam logic [2:0] ACK_NONE    = 3'd0;
  localparam logic [2:0] ACK_PUBACK  = 3'd1;
  localparam logic [2:0] ACK_PUBREC  = 3'd2;
  localparam logic [2:0] ACK_PUBREL  = 3'd3;
  localparam logic [2:0] ACK_PUBCOMP = 3'd4;

  localparam int unsigned LenW       = 28;
  localparam logic [7:0]  LenDataMask = 8'h7F;
  localparam int unsigned LenContBit = 7;
  localparam logic [1:0]  QOS_NONE   = 2'd0;
  localparam logic [1:0]  QOS_ONE    = 2'd1;
  localparam logic [1:0]  QOS_TWO    = 2'd2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [2:0]  byte_role;
    logic [3:0]  packet_type;
    logic [1:0]  qos_level;
    logic        end_of_packet;
    logic [2:0]  ack_kind;
    logic [15:0] ack_packet_id;
    logic [2:0]  peer_ack_kind;
    logic [15:0] peer_packet_id;
    logic        malformed;
  } result_t;

endpackage

[hw/rtl/mqtt_inbound_packet_parser_core.sv]
// ----------------------------------------------------------------------------
// mqtt_inbound_packet_parser_core
// Inbound MQTT byte parser: tags each byte and requests/reports acks.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  in      | input     | in_valid_i / in_ready_o    | rx_byte_i
//  out     | output    | out_valid_o / out_ready_i  | data_byte_o .. malformed_o
//
//  one byte per cycle sustained while out is not stalled
//  the byte sits in an input register, decode runs into the result register
//  in_ready_o drops only when both registers hold items and out is stalled
//  reset clears the parse state to expect a header and empties both registers
// ----------------------------------------------------------------------------
module mqtt_inbound_packet_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  byte_role_o,
  output logic [3:0]  packet_type_o,
  output logic [1:0]  qos_level_o,
  output logic        end_of_packet_o,
  output logic [2:0]  ack_kind_o,
  output logic [15:0] ack_packet_id_o,
  output logic [2:0]  peer_ack_kind_o,
  output logic [15:0] peer_packet_id_o,
  output logic        malformed_o
);

  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               out_valid_q;
  mqttp_pkg::result_t out_res_q;
  mqttp_pkg::result_t dec_res;
  logic               advance;

  // item moves from input register into the result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  mqttp_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .rx_byte_i (in_byte_q),
    .res_o     (dec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      out_res_q <= dec_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_byte_o      = out_res_q.data_byte;
  assign byte_role_o      = out_res_q.byte_role;
  assign packet_type_o    = out_res_q.packet_type;
  assign qos_level_o      = out_res_q.qos_level;
  assign end_of_packet_o  = out_res_q.end_of_packet;
  assign ack_kind_o       = out_res_q.ack_kind;
  assign ack_packet_id_o  = out_res_q.ack_packet_id;
  assign peer_ack_kind_o  = out_res_q.peer_ack_kind;
  assign peer_packet_id_o = out_res_q.peer_packet_id;
  assign malformed_o      = out_res_q.malformed;

  a_malformed_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && malformed_o) |-> (end_of_packet_o && byte_role_o == mqttp_pkg::PH_LENGTH))
    else $error("malformed item does not end a packet on a length byte");

  a_ack_on_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ack_kind_o != mqttp_pkg::ACK_NONE) |-> (byte_role_o == mqttp_pkg::PH_ID))
    else $error("reply requested outside a packet id byte");

  a_peer_not_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && peer_ack_kind_o != mqttp_pkg::ACK_NONE)
      |-> (packet_type_o != mqttp_pkg::TYPE_PUBLISH && byte_role_o == mqttp_pkg::PH_ID))
    else $error("peer ack reported for a non-ack packet");

  a_header_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_role_o == mqttp_pkg::PH_HEADER) |-> !end_of_packet_o)
    else $error("header byte flagged as end of packet");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && in_valid_q) |=> (out_valid_q && in_valid_q))
    else $error("stalled result or pending byte lost");

endmodule

[hw/rtl/mqttp_decode.sv]
// ----------------------------------------------------------------------------
// mqttp_decode
// Parse state and the per-byte decode; state advances when step_i is high.
// ----------------------------------------------------------------------------
module mqttp_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           rx_byte_i,
  output mqttp_pkg::result_t   res_o
);

  localparam int unsigned LenW = mqttp_pkg::LenW;

  logic [2:0]      phase_q, phase_d;
  logic [LenW-1:0] bytes_left_q, bytes_left_d;
  logic [2:0]      len_cnt_q, len_cnt_d;
  logic [7:0]      header_q, header_d;
  logic [15:0]     topic_len_q, topic_len_d;
  logic [15:0]     topic_cnt_q, topic_cnt_d;
  logic [7:0]      id_high_q, id_high_d;
  logic [1:0]      id_cnt_q, id_cnt_d;

  logic [3:0]      cur_type;
  logic [1:0]      cur_qos;
  logic [1:0]      len_idx;
  logic [LenW-1:0] len_ext;
  logic [LenW-1:0] len_shifted;
  logic [LenW-1:0] len_sum;
  logic [LenW-1:0] left_dec;
  logic [15:0]     topic_len_full;
  logic [15:0]     topic_cnt_inc;
  logic [15:0]     id_full;

  assign cur_type       = header_q[7:4];
  assign cur_qos        = (cur_type == mqttp_pkg::TYPE_PUBLISH) ? header_q[2:1]
                                                                 : mqttp_pkg::QOS_NONE;
  assign len_idx        = len_cnt_q[1:0];
  assign len_ext        = LenW'(rx_byte_i & mqttp_pkg::LenDataMask);
  assign len_sum        = bytes_left_q + len_shifted;
  assign left_dec       = bytes_left_q - LenW'(1);
  assign topic_len_full = topic_len_q | {8'h00, rx_byte_i};
  assign topic_cnt_inc  = topic_cnt_q + 16'd1;
  assign id_full        = {id_high_q, rx_byte_i};

  // base-128 group placement, least significant group first
  always_comb begin
    case (len_idx)
      2'd0:    len_shifted = len_ext;
      2'd1:    len_shifted = len_ext << 7;
      2'd2:    len_shifted = len_ext << 14;
      default: len_shifted = len_ext << 21;
    endcase
  end

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    len_cnt_d    = len_cnt_q;
    header_d     = header_q;
    topic_len_d  = topic_len_q;
    topic_cnt_d  = topic_cnt_q;
    id_high_d    = id_high_q;
    id_cnt_d     = id_cnt_q;
    res_o        = '0;
    res_o.data_byte = rx_byte_i;

    case (phase_q)
      mqttp_pkg::PH_LENGTH: begin
        res_o.byte_role = mqttp_pkg::PH_LENGTH;
        bytes_left_d    = len_sum;
        len_cnt_d       = {1'b0, len_idx} + 3'd1;
        if (rx_byte_i[mqttp_pkg::LenContBit]) begin
          if (len_idx == 2'd3) begin
            // length would need a fifth byte: drop the packet
            res_o.malformed     = 1'b1;
            res_o.end_of_packet = 1'b1;
            bytes_left_d        = '0;
            len_cnt_d           = '0;
            phase_d             = mqttp_pkg::PH_HEADER;
          end
        end else if (len_sum == '0) begin
          res_o.end_of_packet = 1'b1;
          phase_d             = mqttp_pkg::PH_HEADER;
        end else begin
          id_cnt_d = '0;
          if (cur_type == mqttp_pkg::TYPE_PUBLISH) begin
            phase_d = mqttp_pkg::PH_TOPLEN;
          end else if (cur_type inside {[mqttp_pkg::TYPE_PUBACK:mqttp_pkg::TYPE_PUBCOMP]}) begin
            phase_d = mqttp_pkg::PH_ID;
          end else begin
            phase_d = mqttp_pkg::PH_OTHER;
          end
        end
      end

      mqttp_pkg::PH_TOPLEN, mqttp_pkg::PH_TOPIC, mqttp_pkg::PH_ID,
      mqttp_pkg::PH_PAYLOAD, mqttp_pkg::PH_OTHER: begin
        res_o.byte_role = phase_q;
        bytes_left_d    = left_dec;
        case (phase_q)
          mqttp_pkg::PH_TOPLEN: begin
            if (id_cnt_q == 2'd0) begin
              topic_len_d = {rx_byte_i, 8'h00};
              id_cnt_d    = 2'd1;
            end else begin
              topic_len_d = topic_len_full;
              topic_cnt_d = '0;
              id_cnt_d    = '0;
              if (topic_len_full != '0) begin
                phase_d = mqttp_pkg::PH_TOPIC;
              end else begin
                phase_d = (cur_qos != mqttp_pkg::QOS_NONE) ? mqttp_pkg::PH_ID
                                                           : mqttp_pkg::PH_PAYLOAD;
              end
            end
          end
          mqttp_pkg::PH_TOPIC: begin
            topic_cnt_d = topic_cnt_inc;
            if (topic_cnt_inc == topic_len_q) begin
              phase_d = (cur_qos != mqttp_pkg::QOS_NONE) ? mqttp_pkg::PH_ID
                                                         : mqttp_pkg::PH_PAYLOAD;
            end
          end
          mqttp_pkg::PH_ID: begin
            if (id_cnt_q == 2'd0) begin
              id_high_d = rx_byte_i;
              id_cnt_d  = 2'd1;
            end else begin
              id_cnt_d = '0;
              if (cur_type == mqttp_pkg::TYPE_PUBLISH) begin
                if (cur_qos == mqttp_pkg::QOS_ONE) begin
                  res_o.ack_kind      = mqttp_pkg::ACK_PUBACK;
                  res_o.ack_packet_id = id_full;
                end else if (cur_qos == mqttp_pkg::QOS_TWO) begin
                  res_o.ack_kind      = mqttp_pkg::ACK_PUBREC;
                  res_o.ack_packet_id = id_full;
                end
                phase_d = mqttp_pkg::PH_PAYLOAD;
              end else begin
                // ack types 4..7 map onto kinds 1..4
                res_o.peer_ack_kind  = 3'(cur_type - mqttp_pkg::TYPE_PUBLISH);
                res_o.peer_packet_id = id_full;
                if (cur_type == mqttp_pkg::TYPE_PUBREC) begin
                  res_o.ack_kind      = mqttp_pkg::ACK_PUBREL;
                  res_o.ack_packet_id = id_full;
                end else if (cur_type == mqttp_pkg::TYPE_PUBREL) begin
                  res_o.ack_kind      = mqttp_pkg::ACK_PUBCOMP;
                  res_o.ack_packet_id = id_full;
                end
                phase_d = mqttp_pkg::PH_OTHER;
              end
            end
          end
          default: begin
          end
        endcase
        // remaining length always wins, even mid-field
        if (left_dec == '0) begin
          res_o.end_of_packet = 1'b1;
          id_cnt_d            = '0;
          phase_d             = mqttp_pkg::PH_HEADER;
        end
      end

      default: begin
        // header byte; unused phase code lands here too
        res_o.byte_role = mqttp_pkg::PH_HEADER;
        header_d        = rx_byte_i;
        bytes_left_d    = '0;
        len_cnt_d       = '0;
        id_cnt_d        = '0;
        phase_d         = mqttp_pkg::PH_LENGTH;
      end
    endcase

    res_o.packet_type = header_d[7:4];
    res_o.qos_level   = (header_d[7:4] == mqttp_pkg::TYPE_PUBLISH) ? header_d[2:1]
                                                                   : mqttp_pkg::QOS_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= mqttp_pkg::PH_HEADER;
      bytes_left_q <= '0;
      len_cnt_q    <= '0;
      header_q     <= '0;
      topic_len_q  <= '0;
      topic_cnt_q  <= '0;
      id_high_q    <= '0;
      id_cnt_q     <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      len_cnt_q    <= len_cnt_d;
      header_q     <= header_d;
      topic_len_q  <= topic_len_d;
      topic_cnt_q  <= topic_cnt_d;
      id_high_q    <= id_high_d;
      id_cnt_q     <= id_cnt_d;
    end
  end

endmodule
